FILE: design/kset_pkg.sv
// Package for the key set report builder.
// Holds widths, operation codes and the map request struct; no dependencies.
package kset_pkg;

  localparam int KEY_W     = 8;
  localparam int FUNC_W    = 2;
  localparam int ROW_W     = 8;
  localparam int MAP_ROWS  = 32;
  localparam int ROW_AW    = 5;
  localparam int BIT_AW    = 3;
  localparam int OUT_SLOTS = 6;
  localparam int FILL_W    = 3;
  localparam int CNT_W     = 9;

  localparam logic [FUNC_W-1:0] FN_PRESS   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELALL  = 2'd2;

  typedef struct packed {
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic              clr;
  } map_req_t;

endpackage

FILE: design/kset_map.sv
// Pressed-key map: 32 rows of 8 key bits with a per-row valid flop.
// Depends on kset_pkg. Registered read; an unwritten or cleared row reads zero.
module kset_map (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kset_pkg::map_req_t      req,
  output logic [kset_pkg::ROW_W-1:0] rd_data
);
  import kset_pkg::*;

  logic [ROW_W-1:0]    mem_r [MAP_ROWS];
  logic [MAP_ROWS-1:0] vld_r;
  logic [ROW_W-1:0]    rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rdata_r <= mem_r[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[req.rd_addr];
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

FILE: design/kset_lsb.sv
// Lowest-set-bit finder shared by the report scan.
// Depends on kset_pkg. Gives the bit index and the mask with that bit removed.
module kset_lsb (
  input  logic [kset_pkg::ROW_W-1:0]  mask,
  output logic                        found,
  output logic [kset_pkg::BIT_AW-1:0] idx,
  output logic [kset_pkg::ROW_W-1:0]  rest
);
  import kset_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = BIT_AW'(i);
      end
    end
  end

  assign found = |mask;
  assign rest  = mask & (mask - ROW_W'(1));

endmodule

FILE: design/key_set_report_builder.sv
// Top level of the key set report builder: sequencer, slot registers, ports.
// Depends on kset_pkg, kset_map and kset_lsb.
//
// Input channel: one transfer per key event. in_tuser[1:0] is the operation
// (press, release, release all), in_tdata[7:0] the keycode.
// Output channel: exactly one transfer per event. out_tuser[0] is set when the
// key set changed. out_tdata has six 8-bit slots, lowest first: on a change the
// smallest pressed keycodes ascending and zero where unused, else all zero.
// With the receiver ready, an event that leaves the set unchanged or releases
// all keys goes from acceptance through the map read and the modify state
// straight to the result. Otherwise the map is scanned row by row, with a read
// and an extract state per 8-key row and the extract state repeating for each
// further key found in the same row, bounded by the single map read port and
// the shared lowest-bit finder. Scanning stops once the slots are full. Only
// one event is in flight; in_tready is low from acceptance until the result
// transfer completes, and a stalled result holds steady. Reset (synchronous,
// rst_n low) empties the map at once through the row valid flops; no clearing
// pass is needed.
module key_set_report_builder #(
  parameter int NUM_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] keycode
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] slot0 .. [47:40] slot5
  output logic [0:0]  out_tuser   // [0] changed
);
  import kset_pkg::*;

  localparam int LIMIT = (NUM_SLOTS < OUT_SLOTS) ? NUM_SLOTS : OUT_SLOTS;
  localparam logic [FILL_W-1:0] LIMIT_C = FILL_W'(LIMIT);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(MAP_ROWS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SEX  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic [ROW_W-1:0]  mask_r, mask_nxt;
  logic              fresh_r, fresh_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              chg_r, chg_nxt;
  logic [KEY_W-1:0]  slot_r [OUT_SLOTS];
  logic [KEY_W-1:0]  slot_nxt [OUT_SLOTS];

  map_req_t         req;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] cur;
  logic             lsb_found;
  logic [BIT_AW-1:0] lsb_idx;
  logic [ROW_W-1:0] lsb_rest;
  logic [ROW_W-1:0] key_bit;

  kset_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  kset_lsb u_lsb (
    .mask  (cur),
    .found (lsb_found),
    .idx   (lsb_idx),
    .rest  (lsb_rest)
  );

  assign cur     = fresh_r ? rd_data : mask_r;
  assign key_bit = ROW_W'(1) << key_r[BIT_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    mask_nxt  = mask_r;
    fresh_nxt = fresh_r;
    fill_nxt  = fill_r;
    chg_nxt   = chg_r;
    for (int i = 0; i < OUT_SLOTS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    req.rd_addr = row_r;
    req.wr_en   = 1'b0;
    req.wr_addr = key_r[KEY_W-1:BIT_AW];
    req.wr_data = rd_data;
    req.clr     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser;
          key_nxt   = in_tdata;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        req.rd_addr = key_r[KEY_W-1:BIT_AW];
        state_nxt   = ST_MOD;
      end
      ST_MOD: begin
        chg_nxt  = 1'b0;
        fill_nxt = '0;
        row_nxt  = '0;
        for (int i = 0; i < OUT_SLOTS; i++) begin
          slot_nxt[i] = '0;
        end
        state_nxt = ST_OUT;
        case (func_r)
          FN_PRESS: begin
            if ((rd_data & key_bit) == '0) begin
              req.wr_en   = 1'b1;
              req.wr_data = rd_data | key_bit;
              cnt_nxt     = cnt_r + CNT_W'(1);
              chg_nxt     = 1'b1;
              state_nxt   = ST_SRD;
            end
          end
          FN_RELEASE: begin
            if ((rd_data & key_bit) != '0) begin
              req.wr_en   = 1'b1;
              req.wr_data = rd_data & ~key_bit;
              cnt_nxt     = cnt_r - CNT_W'(1);
              chg_nxt     = 1'b1;
              state_nxt   = ST_SRD;
            end
          end
          FN_RELALL: begin
            if (cnt_r != '0) begin
              req.clr = 1'b1;
              cnt_nxt = '0;
              chg_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SRD: begin
        fresh_nxt = 1'b1;
        state_nxt = ST_SEX;
      end
      ST_SEX: begin
        fresh_nxt = 1'b0;
        mask_nxt  = lsb_rest;
        if (lsb_found) begin
          for (int i = 0; i < OUT_SLOTS; i++) begin
            if (fill_r == FILL_W'(i)) begin
              slot_nxt[i] = {row_r, lsb_idx};
            end
          end
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (lsb_found && (fill_r + FILL_W'(1) == LIMIT_C)) begin
          state_nxt = ST_OUT;
        end else if (lsb_rest == '0) begin
          if (row_r == LAST_ROW) begin
            state_nxt = ST_OUT;
          end else begin
            row_nxt   = row_r + ROW_AW'(1);
            state_nxt = ST_SRD;
          end
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fresh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    row_r  <= row_nxt;
    mask_r <= mask_nxt;
    fill_r <= fill_nxt;
    chg_r  <= chg_nxt;
    for (int i = 0; i < OUT_SLOTS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tuser  = chg_r;
  always_comb begin
    for (int i = 0; i < OUT_SLOTS; i++) begin
      out_tdata[i*KEY_W +: KEY_W] = slot_r[i];
    end
  end

`ifndef SYNTHESIS
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("result pending while ready");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("item not held alone");

  a_unchanged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("unchanged report not zero");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:8] != '0 |-> out_tdata[15:8] > out_tdata[7:0])
    else $error("slots not ascending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEX |-> fill_r < LIMIT_C) else $error("slot fill overrun");
`endif

endmodule

FILE: tb/sv/key_set_report_checker.sv
// Checker for the key set report builder: watches both stream channels,
// predicts each report from its own key map and compares field by field.
// Depends on kset_pkg for widths and operation codes.
module key_set_report_checker #(
  parameter int NUM_SLOTS = 6
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  input  logic                                        in_tready,
  input  logic [kset_pkg::KEY_W-1:0]                  in_tdata,
  input  logic [kset_pkg::FUNC_W-1:0]                 in_tuser,
  input  logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic [kset_pkg::OUT_SLOTS*kset_pkg::KEY_W-1:0] out_tdata,
  input  logic [0:0]                                  out_tuser,
  output int                                          fail_count,
  output int                                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kset_pkg::*;

  typedef struct packed {
    logic                       changed;
    logic [OUT_SLOTS*KEY_W-1:0] slots;
  } key_report_t;

  logic [255:0] held_keys;
  key_report_t  report_q[$];
  int           mismatches;
  int           report_idx;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    mismatches    = 0;
    report_idx    = 0;
    held_keys     = '0;
  end

  function automatic key_report_t apply_key_event(logic [FUNC_W-1:0] fn,
                                                  logic [KEY_W-1:0] key);
    key_report_t rpt;
    int          filled;
    int          shown;
    rpt    = '0;
    filled = 0;
    shown  = (NUM_SLOTS < OUT_SLOTS) ? NUM_SLOTS : OUT_SLOTS;
    case (fn)
      FN_PRESS: begin
        if (!held_keys[key]) begin
          held_keys[key] = 1'b1;
          rpt.changed    = 1'b1;
        end
      end
      FN_RELEASE: begin
        if (held_keys[key]) begin
          held_keys[key] = 1'b0;
          rpt.changed    = 1'b1;
        end
      end
      FN_RELALL: begin
        if (held_keys != '0) begin
          held_keys   = '0;
          rpt.changed = 1'b1;
        end
      end
      default: ;
    endcase
    if (rpt.changed) begin
      for (int k = 0; k < 256; k++) begin
        if (held_keys[k] && filled < shown) begin
          rpt.slots[filled*KEY_W +: KEY_W] = KEY_W'(k);
          filled++;
        end
      end
    end
    return rpt;
  endfunction

  always @(posedge clk) begin
    key_report_t want;
    logic        bad;
    if (!rst_n) begin
      held_keys = '0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        report_q.push_back(apply_key_event(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report %0d: changed %0d slots %h",
                     report_idx, out_tuser[0], out_tdata);
        end else begin
          want = report_q.pop_front();
          bad  = (want.changed !== out_tuser[0]);
          for (int s = 0; s < OUT_SLOTS; s++)
            if (want.slots[s*KEY_W +: KEY_W] !== out_tdata[s*KEY_W +: KEY_W])
              bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("report %0d mismatch: exp changed %0d slots %h, got changed %0d slots %h",
                       report_idx, want.changed, want.slots, out_tuser[0], out_tdata);
          end
        end
        report_idx++;
      end
    end
    fail_count    <= mismatches;
    pending_count <= report_q.size();
  end

endmodule

FILE: tb/sv/key_set_report_builder_tb.sv
// Testbench top for the key set report builder: clock, reset, key event
// stimulus, receiver back-pressure and the verdict.
// Depends on kset_pkg, key_set_report_builder and key_set_report_checker.
module key_set_report_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kset_pkg::*;

  localparam int                NUM_SLOTS    = 6;
  localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;
  localparam int                RANDOM_ITEMS = 1828;
  localparam int                LONG_STALL   = 700;
  localparam int                DRAIN_CYCLES = 100;
  localparam int                CYCLE_LIMIT  = 1000000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [KEY_W-1:0]           in_tdata;   // [7:0] keycode
  logic [FUNC_W-1:0]          in_tuser;   // [1:0] func
  logic                       out_tvalid;
  logic                       out_tready;
  logic [OUT_SLOTS*KEY_W-1:0] out_tdata;  // [7:0] slot0 .. [47:40] slot5
  logic [0:0]                 out_tuser;  // [0] changed
  int                         fail_count;
  int                         pending_count;
  int                         cycle_count;
  int                         burst_left;
  logic [KEY_W-1:0]           key_pool[12];

  key_set_report_builder #(.NUM_SLOTS(NUM_SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  key_set_report_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // holds valid through a burst, drops it for a random gap between bursts
  task automatic send_key_event(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key);
    in_tuser  = fn;
    in_tdata  = key;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid  = 1'b0;
      burst_left = $urandom_range(0, 7);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic refill_key_pool();
    int base;
    base = $urandom_range(0, 255 - 12);
    for (int i = 0; i < 12; i++)
      key_pool[i] = ($urandom_range(0, 1) == 0) ? KEY_W'(base + i) : KEY_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) key_pool[0] = 8'd0;
    if ($urandom_range(0, 3) == 0) key_pool[11] = 8'd255;
  endtask

  initial begin
    int               pick;
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0]  key;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty set, no-change cases and the unused code
    send_key_event(FN_RELALL, 8'h00);
    send_key_event(FN_RELEASE, 8'h05);
    send_key_event(FN_UNUSED, 8'hA5);
    // keycode zero is held but reads as an empty slot
    send_key_event(FN_PRESS, 8'h00);
    send_key_event(FN_PRESS, 8'h00);
    send_key_event(FN_PRESS, 8'hFF);
    send_key_event(FN_PRESS, 8'h80);
    send_key_event(FN_PRESS, 8'h07);
    send_key_event(FN_PRESS, 8'h40);
    send_key_event(FN_PRESS, 8'hC8);
    send_key_event(FN_PRESS, 8'h21);
    // more than six held: largest keys drop out of the report
    send_key_event(FN_PRESS, 8'h01);
    send_key_event(FN_RELEASE, 8'h00);
    send_key_event(FN_RELEASE, 8'h00);
    send_key_event(FN_UNUSED, 8'h5A);
    send_key_event(FN_RELEASE, 8'hC8);
    send_key_event(FN_RELALL, 8'hFF);
    send_key_event(FN_RELALL, 8'h00);
    send_key_event(FN_PRESS, 8'hFF);
    send_key_event(FN_RELEASE, 8'hFF);
    send_key_event(FN_PRESS, 8'h55);
    send_key_event(FN_PRESS, 8'hAA);
    send_key_event(FN_RELALL, 8'h55);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) refill_key_pool();
      pick = $urandom_range(0, 99);
      if (pick < 48)      fn = FN_PRESS;
      else if (pick < 88) fn = FN_RELEASE;
      else if (pick < 95) fn = FN_RELALL;
      else                fn = FN_UNUSED;
      key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom_range(0, 255))
                                        : key_pool[$urandom_range(0, 11)];
      send_key_event(fn, key);
    end
    in_tvalid = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: segments of steady, random, sparse and toggling ready, one long hold-off
  initial begin
    int seg;
    int mode;
    seg = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (seg == 3) begin
        out_tready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(20, 300)) begin
          case (mode)
            0:       out_tready = 1'b1;
            1:       out_tready = $urandom_range(0, 1);
            2:       out_tready = ($urandom_range(0, 3) == 0);
            default: out_tready = ~out_tready;
          endcase
          @(negedge clk);
        end
      end
      seg++;
    end
  end

endmodule
